// ----- hw/rtl/ffsa_pkg.sv -----
package ffsa_pkg;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LIST    = 2'd2;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOGAP    = 3'd1;
  localparam logic [2:0] STAT_NOTFOUND = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  localparam logic [31:0] MEM_SIZE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_LIST
  } state_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] start;
    logic [31:0] last;
  } ent_t;

  typedef struct packed {
    logic        eval;
    logic        insert;
    logic        remove;
    logic        is_alloc;
    logic [31:0] size;
    logic [15:0] rid;
    logic [31:0] mem_size;
    logic [15:0] new_id;
  } ctl_t;

endpackage

// ----- hw/rtl/ffsa_cell.sv -----
module ffsa_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 5
) (
  input  logic              clk,
  input  ffsa_pkg::ctl_t    ctl,
  input  logic [CNT_W-1:0]  count,
  input  ffsa_pkg::ent_t    left_ent,
  input  ffsa_pkg::ent_t    right_ent,
  input  logic              hit_in,
  output ffsa_pkg::ent_t    ent,
  output logic              hit_out,
  output logic              sel,
  output ffsa_pkg::ent_t    res_ent
);

  logic           flag;
  logic           occ;
  logic           open;
  logic [32:0]    lo;
  logic [32:0]    hi;
  logic           fit;
  logic           match;
  ffsa_pkg::ent_t new_ent;

  always_comb begin
    occ  = CNT_W'(CELL_IDX) < count;
    open = CNT_W'(CELL_IDX) <= count;
    // gap opens right after the left neighbor, or at address zero
    if (CELL_IDX == 0) begin
      lo = '0;
    end else begin
      lo = {1'b0, left_ent.last} + 33'd1;
    end
    // past the last segment the gap runs to the top of memory
    hi    = occ ? {1'b0, ent.start} : {1'b0, ctl.mem_size};
    fit   = open && ({1'b0, hi} >= ({1'b0, lo} + {2'b00, ctl.size}));
    match = occ && (ent.owner == ctl.rid);
    new_ent.owner = ctl.new_id;
    new_ent.start = lo[31:0];
    new_ent.last  = lo[31:0] + ctl.size - 32'd1;
    hit_out = hit_in | flag;
    sel     = flag & ~hit_in;
    if (sel) begin
      res_ent = ctl.is_alloc ? new_ent : ent;
    end else begin
      res_ent = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      flag <= ctl.is_alloc ? fit : match;
    end
    if (ctl.insert) begin
      if (sel) begin
        ent <= new_ent;
      end else if (hit_in) begin
        ent <= left_ent;
      end
    end else if (ctl.remove) begin
      // close the hole: everything from the freed slot up moves down one
      if (hit_out) begin
        ent <= right_ent;
      end
    end
  end

endmodule

// ----- hw/rtl/first_fit_segment_allocator.sv -----
// Channel | Signals                                   | Direction
// request | in_valid/in_ready, kind, request_size,     | in
//         | release_id                                |
// result  | out_valid/out_ready, status, proc_id,     | out
//         | seg_base, seg_last, last_of_run           |
// config  | cfg_valid/cfg_ready, cfg_data             | in
//
// Allocate and release first evaluate every gap or owner in the cell chain,
// then pick the first hit and shift the chain.
// List emits one segment per cycle while results are taken; an empty table gives one EMPTY result.
// A result waits in the output register; a stalled result holds the apply
// or list step until it is taken. Reset empties the table, zeroes the id
// counter and sets memory size to 65536.
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] request_size,
  input  logic [15:0] release_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] proc_id,
  output logic [31:0] seg_base,
  output logic [31:0] seg_last,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = $clog2(MAX_SEGMENTS);

  ffsa_pkg::state_t state, state_next;
  logic [CNT_W-1:0] seg_count, seg_count_next;
  logic [15:0]      id_counter, id_counter_next;
  logic [IDX_W-1:0] list_idx, list_idx_next;
  logic [31:0]      memory_size;
  logic [1:0]       kind_q;
  logic [31:0]      size_q;
  logic [15:0]      rid_q;

  ffsa_pkg::ctl_t   ctl;
  ffsa_pkg::ent_t   ent_all [MAX_SEGMENTS];
  ffsa_pkg::ent_t   res_all [MAX_SEGMENTS];
  ffsa_pkg::ent_t   res_bus;
  logic [MAX_SEGMENTS:0]   hit;
  logic [MAX_SEGMENTS-1:0] sel_vec;

  logic        out_free;
  logic        out_load;
  logic        do_eval;
  logic        do_insert;
  logic        do_remove;
  logic [2:0]  o_status;
  logic [15:0] o_id;
  logic [31:0] o_base;
  logic [31:0] o_last;
  logic        o_fin;
  logic [15:0] next_id;

  assign cfg_ready = 1'b1;
  assign hit[0]    = 1'b0;
  assign next_id   = 16'(id_counter + 16'd1);

  always_comb begin
    ctl.eval     = do_eval;
    ctl.insert   = do_insert;
    ctl.remove   = do_remove;
    ctl.is_alloc = (kind_q == ffsa_pkg::KIND_ALLOC);
    ctl.size     = size_q;
    ctl.rid      = rid_q;
    ctl.mem_size = memory_size;
    ctl.new_id   = next_id;
  end

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    ffsa_pkg::ent_t left_ent;
    ffsa_pkg::ent_t right_ent;
    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid
      assign left_ent = ent_all[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_end
      assign right_ent = ent_all[i];
    end else begin : g_inner
      assign right_ent = ent_all[i+1];
    end
    ffsa_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (seg_count),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .hit_in    (hit[i]),
      .ent       (ent_all[i]),
      .hit_out   (hit[i+1]),
      .sel       (sel_vec[i]),
      .res_ent   (res_all[i])
    );
  end

  // only the first hit drives the bus
  always_comb begin
    res_bus = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      res_bus = res_bus | res_all[i];
    end
  end

  always_comb begin
    state_next      = state;
    seg_count_next  = seg_count;
    id_counter_next = id_counter;
    list_idx_next   = list_idx;
    in_ready        = 1'b0;
    out_load        = 1'b0;
    do_eval         = 1'b0;
    do_insert       = 1'b0;
    do_remove       = 1'b0;
    o_status        = ffsa_pkg::STAT_OK;
    o_id            = '0;
    o_base          = '0;
    o_last          = '0;
    o_fin           = 1'b0;
    out_free        = ~out_valid | out_ready;

    case (state)
      ffsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ffsa_pkg::ST_EVAL: begin
        do_eval    = 1'b1;
        state_next = ffsa_pkg::ST_APPLY;
      end
      ffsa_pkg::ST_APPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_fin      = 1'b1;
          in_ready   = 1'b1;
          state_next = ffsa_pkg::ST_IDLE;
          if (kind_q == ffsa_pkg::KIND_ALLOC) begin
            id_counter_next = next_id;
            o_id            = next_id;
            if (seg_count == CNT_W'(MAX_SEGMENTS)) begin
              o_status = ffsa_pkg::STAT_FULL;
            end else if (size_q == 32'd0 || !hit[MAX_SEGMENTS]) begin
              o_status = ffsa_pkg::STAT_NOGAP;
            end else begin
              o_status       = ffsa_pkg::STAT_OK;
              o_base         = res_bus.start;
              o_last         = res_bus.last;
              do_insert      = 1'b1;
              seg_count_next = CNT_W'(seg_count + 1'b1);
            end
          end else begin
            o_id = rid_q;
            if (hit[MAX_SEGMENTS]) begin
              o_status       = ffsa_pkg::STAT_OK;
              o_base         = res_bus.start;
              o_last         = res_bus.last;
              do_remove      = 1'b1;
              seg_count_next = CNT_W'(seg_count - 1'b1);
            end else begin
              o_status = ffsa_pkg::STAT_NOTFOUND;
            end
          end
        end
      end
      ffsa_pkg::ST_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          if (seg_count == '0) begin
            o_status   = ffsa_pkg::STAT_EMPTY;
            o_fin      = 1'b1;
            state_next = ffsa_pkg::ST_IDLE;
          end else begin
            o_status = ffsa_pkg::STAT_OK;
            o_id     = ent_all[list_idx].owner;
            o_base   = ent_all[list_idx].start;
            o_last   = ent_all[list_idx].last;
            o_fin    = (CNT_W'(CNT_W'(list_idx) + 1'b1) == seg_count);
            if (o_fin) begin
              state_next = ffsa_pkg::ST_IDLE;
            end else begin
              list_idx_next = IDX_W'(list_idx + 1'b1);
            end
          end
        end
      end
      default: begin
        state_next = ffsa_pkg::ST_IDLE;
      end
    endcase

    if (in_ready && in_valid) begin
      case (kind)
        ffsa_pkg::KIND_ALLOC, ffsa_pkg::KIND_RELEASE: begin
          state_next = ffsa_pkg::ST_EVAL;
        end
        ffsa_pkg::KIND_LIST: begin
          state_next    = ffsa_pkg::ST_LIST;
          list_idx_next = '0;
        end
        default: begin
          state_next = ffsa_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ffsa_pkg::ST_IDLE;
      seg_count   <= '0;
      id_counter  <= '0;
      list_idx    <= '0;
      memory_size <= ffsa_pkg::MEM_SIZE_RESET;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      seg_count  <= seg_count_next;
      id_counter <= id_counter_next;
      list_idx   <= list_idx_next;
      if (cfg_valid && cfg_ready) begin
        memory_size <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_q <= kind;
      size_q <= request_size;
      rid_q  <= release_id;
    end
    if (out_load) begin
      status      <= o_status;
      proc_id     <= o_id;
      seg_base    <= o_base;
      seg_last    <= o_last;
      last_of_run <= o_fin;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above table size");

  a_one_first: assert property (@(posedge clk) disable iff (rst)
    state == ffsa_pkg::ST_APPLY |-> $onehot0(sel_vec))
    else $error("more than one cell selected");

  a_ins_rem: assert property (@(posedge clk) disable iff (rst)
    !(do_insert && do_remove))
    else $error("insert and remove in one cycle");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> seg_count == CNT_W'($past(seg_count) + 1'b1))
    else $error("insert did not grow the table");

  a_eval_apply: assert property (@(posedge clk) disable iff (rst)
    state == ffsa_pkg::ST_EVAL |=> state == ffsa_pkg::ST_APPLY)
    else $error("evaluate not followed by apply");
`endif

endmodule
